// File: design/u16u8_pkg.sv
package u16u8_pkg;

  localparam int unsigned UNIT_W   = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CODE_W   = 21;
  localparam int unsigned MAX_BYTES = 4;

  // Status codes reported on the end-of-string beat.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SURROGATE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CAPACITY  = 2'd2;

  // Register map (byte addresses).
  localparam int unsigned          APB_ADDR_W          = 2;
  localparam logic [APB_ADDR_W-1:0] REG_OUTPUT_CAPACITY = 2'd0;
  localparam logic [COUNT_W-1:0]    CAPACITY_RESET      = 16'hFFFF;

  // Top six bits of a surrogate code unit.
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;  // D800-DBFF
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;  // DC00-DFFF

  localparam logic [CODE_W-1:0] SUPPL_BASE = 21'h10000;

  // UTF-8 lead and continuation prefixes.
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

// File: design/utf16_to_utf8_encoder.sv
// UTF-16 to UTF-8 encoder. One UTF-16 code unit enters per in_ beat and the
// UTF-8 bytes of the character it completes leave one per out_ beat: 1 to 3
// bytes for a plain unit, 4 bytes for a low surrogate that follows a high
// surrogate, and none for a high surrogate (held until the next unit) or for a
// unit dropped after an error. A zero unit ends the string and produces one
// end-of-string beat (tuser high, data byte 0) that carries the byte count and
// the status: ok, bad surrogate pairing, or capacity exceeded. After an error
// the rest of the string up to the zero unit is dropped. The output_capacity
// register (address 0, reset 65535) limits the bytes of one string; a
// character that does not fit is not emitted and flags capacity exceeded.
// Write it only while the block is idle. Timing: a unit is decoded from the input
// register once the output register is free, and its bytes are loaded into a
// four-byte output register, which drains one byte per cycle while out_tready is
// high; the input takes a new unit in the same cycle that the output register
// hands over its last byte, so one-byte characters stream at one per clock while
// the output is ready.
module utf16_to_utf8_encoder (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] code_unit
  // Output stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_byte, [23:8] bytes_written,
                                  // [25:24] status, [31:26] zero
  output logic        out_tlast,  // last_of_run
  output logic        out_tuser,  // [0] end_of_string
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [u16u8_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = u16u8_pkg::COUNT_W;
  localparam int unsigned SW = u16u8_pkg::STATUS_W;

  // Input register.
  logic                          in_valid_r;
  logic [u16u8_pkg::UNIT_W-1:0]  in_unit_r;

  // String state.
  logic [CW-1:0] cap_r;
  logic [9:0]    pend_bits_r, pend_bits_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [CW-1:0] space_r, space_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] err_r, err_nxt;

  // Output register: up to four bytes, drained by res_idx_r.
  logic                res_valid_r;
  u16u8_pkg::byte_t    res_bytes_r [u16u8_pkg::MAX_BYTES];
  logic [1:0]          res_last_r;
  logic [1:0]          res_idx_r;
  logic [CW-1:0]       res_base_r;
  logic                res_eos_r;
  logic [SW-1:0]       res_status_r;

  // Decode results.
  logic                emit;
  logic                emit_eos;
  logic [SW-1:0]       emit_status;
  u16u8_pkg::byte_t    enc_bytes [u16u8_pkg::MAX_BYTES];
  logic [2:0]          enc_n;
  logic [u16u8_pkg::CODE_W-1:0] code;
  logic                is_high, is_low;
  logic                pair_code;
  logic                cfg_write;

  logic res_done, res_free, proc_fire;

  assign res_done  = res_valid_r && out_tready && (res_idx_r == res_last_r);
  assign res_free  = !res_valid_r || res_done;
  assign proc_fire = in_valid_r && res_free;
  assign in_tready = !in_valid_r || res_free;

  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr == u16u8_pkg::REG_OUTPUT_CAPACITY) ? {16'd0, cap_r} : 32'd0;

  assign is_high = (in_unit_r[15:10] == u16u8_pkg::HIGH_SURR_TAG);
  assign is_low  = (in_unit_r[15:10] == u16u8_pkg::LOW_SURR_TAG);

  // The character code: a plain unit, or a surrogate pair joined.
  assign pair_code = pend_valid_r && is_low;
  assign code = pair_code ? (u16u8_pkg::SUPPL_BASE + {1'b0, pend_bits_r, in_unit_r[9:0]})
                          : {5'd0, in_unit_r};

  // UTF-8 encoding, first byte at index 0.
  always_comb begin
    enc_bytes[0] = code[7:0];
    enc_bytes[1] = 8'd0;
    enc_bytes[2] = 8'd0;
    enc_bytes[3] = 8'd0;
    enc_n        = 3'd1;
    if (code[20:16] != 5'd0) begin
      enc_bytes[0] = u16u8_pkg::LEAD4 | {5'd0, code[20:18]};
      enc_bytes[1] = u16u8_pkg::CONT  | {2'd0, code[17:12]};
      enc_bytes[2] = u16u8_pkg::CONT  | {2'd0, code[11:6]};
      enc_bytes[3] = u16u8_pkg::CONT  | {2'd0, code[5:0]};
      enc_n        = 3'd4;
    end else if (code[15:11] != 5'd0) begin
      enc_bytes[0] = u16u8_pkg::LEAD3 | {4'd0, code[15:12]};
      enc_bytes[1] = u16u8_pkg::CONT  | {2'd0, code[11:6]};
      enc_bytes[2] = u16u8_pkg::CONT  | {2'd0, code[5:0]};
      enc_n        = 3'd3;
    end else if (code[10:7] != 4'd0) begin
      enc_bytes[0] = u16u8_pkg::LEAD2 | {3'd0, code[10:6]};
      enc_bytes[1] = u16u8_pkg::CONT  | {2'd0, code[5:0]};
      enc_n        = 3'd2;
    end
  end

  // String state update for the unit in the input register.
  always_comb begin
    pend_bits_nxt  = pend_bits_r;
    pend_valid_nxt = pend_valid_r;
    space_nxt      = space_r;
    count_nxt      = count_r;
    err_nxt        = err_r;
    emit           = 1'b0;
    emit_eos       = 1'b0;
    emit_status    = u16u8_pkg::STATUS_OK;
    if (in_unit_r == '0) begin
      // End of string: report, then start a fresh string.
      emit     = 1'b1;
      emit_eos = 1'b1;
      if (err_r == u16u8_pkg::STATUS_OK && pend_valid_r) begin
        emit_status = u16u8_pkg::STATUS_SURROGATE;
      end else begin
        emit_status = err_r;
      end
      pend_bits_nxt  = '0;
      pend_valid_nxt = 1'b0;
      space_nxt      = cap_r;
      count_nxt      = '0;
      err_nxt        = u16u8_pkg::STATUS_OK;
    end else if (err_r != u16u8_pkg::STATUS_OK) begin
      // Dropped until the end of the string.
    end else if (pend_valid_r && !is_low) begin
      pend_bits_nxt  = '0;
      pend_valid_nxt = 1'b0;
      err_nxt        = u16u8_pkg::STATUS_SURROGATE;
    end else if (!pend_valid_r && is_high) begin
      pend_bits_nxt  = in_unit_r[9:0];
      pend_valid_nxt = 1'b1;
    end else if (!pend_valid_r && is_low) begin
      err_nxt = u16u8_pkg::STATUS_SURROGATE;
    end else begin
      // A complete character: plain unit or a closed surrogate pair.
      pend_bits_nxt  = '0;
      pend_valid_nxt = 1'b0;
      if (space_r < {13'd0, enc_n}) begin
        err_nxt = u16u8_pkg::STATUS_CAPACITY;
      end else begin
        emit      = 1'b1;
        space_nxt = space_r - {13'd0, enc_n};
        count_nxt = count_r + {13'd0, enc_n};
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_unit_r <= in_tdata;
    end
  end

  // String state and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= u16u8_pkg::CAPACITY_RESET;
      pend_bits_r  <= '0;
      pend_valid_r <= 1'b0;
      space_r      <= u16u8_pkg::CAPACITY_RESET;
      count_r      <= '0;
      err_r        <= u16u8_pkg::STATUS_OK;
    end else if (cfg_write) begin
      // Capacity applies to the string in progress, less what it already used.
      cap_r   <= pwdata[CW-1:0];
      space_r <= (pwdata[CW-1:0] > count_r) ? (pwdata[CW-1:0] - count_r) : '0;
    end else if (proc_fire) begin
      pend_bits_r  <= pend_bits_nxt;
      pend_valid_r <= pend_valid_nxt;
      space_r      <= space_nxt;
      count_r      <= count_nxt;
      err_r        <= err_nxt;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      res_idx_r   <= '0;
    end else if (proc_fire) begin
      res_valid_r <= emit;
      res_idx_r   <= '0;
    end else if (res_done) begin
      res_valid_r <= 1'b0;
    end else if (res_valid_r && out_tready) begin
      res_idx_r <= res_idx_r + 2'd1;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (proc_fire && emit) begin
      res_base_r   <= count_r;
      res_eos_r    <= emit_eos;
      res_status_r <= emit_status;
      if (emit_eos) begin
        res_bytes_r[0] <= 8'd0;
        res_bytes_r[1] <= 8'd0;
        res_bytes_r[2] <= 8'd0;
        res_bytes_r[3] <= 8'd0;
        res_last_r     <= 2'd0;
      end else begin
        res_bytes_r[0] <= enc_bytes[0];
        res_bytes_r[1] <= enc_bytes[1];
        res_bytes_r[2] <= enc_bytes[2];
        res_bytes_r[3] <= enc_bytes[3];
        res_last_r     <= 2'(enc_n - 3'd1);
      end
    end
  end

  logic [CW-1:0] bytes_written;
  assign bytes_written = res_eos_r ? res_base_r
                                   : (res_base_r + {14'd0, res_idx_r} + 16'd1);

  assign out_tvalid = res_valid_r;
  assign out_tdata  = {6'd0, res_status_r, bytes_written, res_bytes_r[res_idx_r]};
  assign out_tlast  = (res_idx_r == res_last_r);
  assign out_tuser  = res_eos_r;

endmodule

// File: bench/tb_utf16_to_utf8_encoder.sv
module tb_utf16_to_utf8_encoder;
  import u16u8_pkg::*;

  // Cycles without any accepted beat before the run is declared hung. The
  // slowest legal stretch is a sender gap plus four output beats, each behind
  // a full receiver stall, or the settle pause before a register write.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles allowed for a unit that produces no beat to leave the pipeline.
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_UNITS = 410;

  // One output beat as the block presents it.
  typedef struct packed {
    logic [BYTE_W-1:0]   bval;
    logic                last;
    logic                eos;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } utf8_beat_t;

  // A row of the directed table either feeds a code unit or rewrites the
  // capacity register. For units, the expectation is either taken from the
  // predictor, stated as "no beat", or typed in as a single beat.
  typedef enum logic [0:0] {ROW_UNIT, ROW_CAP} row_op_t;
  typedef enum logic [1:0] {EXP_PRED, EXP_NONE, EXP_BEAT} exp_kind_t;

  typedef struct packed {
    row_op_t          op;
    exp_kind_t        kind;
    logic [UNIT_W-1:0] val;
    utf8_beat_t       beat;
  } dir_row_t;

  localparam utf8_beat_t NO_BEAT = '0;
  localparam int DIR_N = 37;

  // Directed stimulus. The string counts in the typed terminators follow
  // from the bytes of the rows above them.
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // An empty string gives a bare terminator.
    '{ROW_UNIT, EXP_BEAT, 16'h0000, '{8'h00, 1'b1, 1'b1, 16'd0, STATUS_OK}},
    // A one-byte character and the top of the one-byte range, then the edges of the two- and three-byte ranges.
    '{ROW_UNIT, EXP_BEAT, 16'h0041, '{8'h41, 1'b1, 1'b0, 16'd1, STATUS_OK}},
    '{ROW_UNIT, EXP_BEAT, 16'h007F, '{8'h7F, 1'b1, 1'b0, 16'd2, STATUS_OK}},
    '{ROW_UNIT, EXP_PRED, 16'h0080, NO_BEAT},
    '{ROW_UNIT, EXP_PRED, 16'h07FF, NO_BEAT},
    '{ROW_UNIT, EXP_PRED, 16'h0800, NO_BEAT},
    '{ROW_UNIT, EXP_PRED, 16'hFFFF, NO_BEAT},
    // Lowest and highest surrogate pairs.
    '{ROW_UNIT, EXP_NONE, 16'hD800, NO_BEAT},
    '{ROW_UNIT, EXP_PRED, 16'hDC00, NO_BEAT},
    '{ROW_UNIT, EXP_NONE, 16'hDBFF, NO_BEAT},
    '{ROW_UNIT, EXP_PRED, 16'hDFFF, NO_BEAT},
    '{ROW_UNIT, EXP_BEAT, 16'h0000, '{8'h00, 1'b1, 1'b1, 16'd20, STATUS_OK}},
    // A lone low surrogate poisons the string; later units are dropped.
    '{ROW_UNIT, EXP_NONE, 16'hDC00, NO_BEAT},
    '{ROW_UNIT, EXP_NONE, 16'h0041, NO_BEAT},
    '{ROW_UNIT, EXP_BEAT, 16'h0000, '{8'h00, 1'b1, 1'b1, 16'd0, STATUS_SURROGATE}},
    // A high surrogate followed by a plain unit swallows that unit.
    '{ROW_UNIT, EXP_NONE, 16'hD800, NO_BEAT},
    '{ROW_UNIT, EXP_NONE, 16'h0041, NO_BEAT},
    '{ROW_UNIT, EXP_BEAT, 16'h0000, '{8'h00, 1'b1, 1'b1, 16'd0, STATUS_SURROGATE}},
    // A high surrogate right before the end of the string.
    '{ROW_UNIT, EXP_NONE, 16'hDBFF, NO_BEAT},
    '{ROW_UNIT, EXP_BEAT, 16'h0000, '{8'h00, 1'b1, 1'b1, 16'd0, STATUS_SURROGATE}},
    // A three-byte character that does not fit in the room that is left.
    '{ROW_CAP,  EXP_NONE, 16'd3,    NO_BEAT},
    '{ROW_UNIT, EXP_BEAT, 16'h0041, '{8'h41, 1'b1, 1'b0, 16'd1, STATUS_OK}},
    '{ROW_UNIT, EXP_NONE, 16'h0800, NO_BEAT},
    '{ROW_UNIT, EXP_BEAT, 16'h0000, '{8'h00, 1'b1, 1'b1, 16'd1, STATUS_CAPACITY}},
    // Zero capacity rejects even one byte.
    '{ROW_CAP,  EXP_NONE, 16'd0,    NO_BEAT},
    '{ROW_UNIT, EXP_NONE, 16'h0041, NO_BEAT},
    '{ROW_UNIT, EXP_BEAT, 16'h0000, '{8'h00, 1'b1, 1'b1, 16'd0, STATUS_CAPACITY}},
    // Capacity lowered in the middle of a string leaves no room at all.
    '{ROW_CAP,  EXP_NONE, 16'hFFFF, NO_BEAT},
    '{ROW_UNIT, EXP_BEAT, 16'h0042, '{8'h42, 1'b1, 1'b0, 16'd1, STATUS_OK}},
    '{ROW_CAP,  EXP_NONE, 16'd1,    NO_BEAT},
    '{ROW_UNIT, EXP_NONE, 16'h0043, NO_BEAT},
    '{ROW_UNIT, EXP_BEAT, 16'h0000, '{8'h00, 1'b1, 1'b1, 16'd1, STATUS_CAPACITY}},
    // A four-byte character that fills the capacity exactly.
    '{ROW_CAP,  EXP_NONE, 16'd4,    NO_BEAT},
    '{ROW_UNIT, EXP_NONE, 16'hD83D, NO_BEAT},
    '{ROW_UNIT, EXP_PRED, 16'hDE00, NO_BEAT},
    '{ROW_UNIT, EXP_BEAT, 16'h0000, '{8'h00, 1'b1, 1'b1, 16'd4, STATUS_OK}},
    '{ROW_CAP,  EXP_NONE, 16'hFFFF, NO_BEAT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  utf16_to_utf8_encoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block's string state and capacity register.
  logic [COUNT_W-1:0]  capacity;
  logic [9:0]          held_high;
  logic                held_valid;
  logic [COUNT_W-1:0]  room_left;
  logic [COUNT_W-1:0]  string_bytes;
  logic [STATUS_W-1:0] string_status;

  // Beats the predictor produced for the latest unit, and all beats still
  // owed by the block, oldest first.
  utf8_beat_t utf8_pending [$];
  utf8_beat_t utf8_expected [$];

  int mismatches = 0;
  int out_beats = 0;
  int sent_units = 0;
  bit sender_eager = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("mismatch at out beat %0d: %s got %0h expected %0h", out_beats, what, got, want);
  endtask

  task automatic clear_string();
    held_high = '0;
    held_valid = 1'b0;
    room_left = capacity;
    string_bytes = '0;
    string_status = STATUS_OK;
  endtask

  task automatic set_capacity(input logic [COUNT_W-1:0] v);
    capacity = v;
    room_left = (capacity > string_bytes) ? capacity - string_bytes : '0;
  endtask

  // Encode one code point into UTF-8 beats, or flag a capacity error if the
  // whole character does not fit; a character is never split.
  task automatic push_utf8_char(input logic [CODE_W-1:0] code);
    logic [7:0] b [4];
    int n;
    if (code < 21'h80) begin
      b[0] = code[7:0];
      n = 1;
    end else if (code < 21'h800) begin
      b[0] = LEAD2 | {3'b000, code[10:6]};
      b[1] = CONT | {2'b00, code[5:0]};
      n = 2;
    end else if (code < SUPPL_BASE) begin
      b[0] = LEAD3 | {4'b0000, code[15:12]};
      b[1] = CONT | {2'b00, code[11:6]};
      b[2] = CONT | {2'b00, code[5:0]};
      n = 3;
    end else begin
      b[0] = LEAD4 | {5'b00000, code[20:18]};
      b[1] = CONT | {2'b00, code[17:12]};
      b[2] = CONT | {2'b00, code[11:6]};
      b[3] = CONT | {2'b00, code[5:0]};
      n = 4;
    end
    if (room_left < n) begin
      string_status = STATUS_CAPACITY;
    end else begin
      for (int i = 0; i < n; i++) begin
        string_bytes = string_bytes + 1'b1;
        utf8_pending.push_back('{b[i], (i == n - 1), 1'b0, string_bytes, STATUS_OK});
      end
      room_left = room_left - n[COUNT_W-1:0];
    end
  endtask

  // Predict the beats caused by one accepted code unit.
  task automatic encode_unit(input logic [UNIT_W-1:0] u);
    utf8_pending.delete();
    if (u == '0) begin
      // A high surrogate still waiting at the end counts as a bad pair.
      if (string_status == STATUS_OK && held_valid) begin
        string_status = STATUS_SURROGATE;
      end
      utf8_pending.push_back('{8'h00, 1'b1, 1'b1, string_bytes, string_status});
      clear_string();
    end else if (string_status != STATUS_OK) begin
      // The rest of a failed string is dropped.
    end else if (held_valid) begin
      held_valid = 1'b0;
      if (u[15:10] == LOW_SURR_TAG) begin
        push_utf8_char(SUPPL_BASE + {1'b0, held_high, u[9:0]});
      end else begin
        string_status = STATUS_SURROGATE;
      end
      held_high = '0;
    end else if (u[15:10] == HIGH_SURR_TAG) begin
      held_high = u[9:0];
      held_valid = 1'b1;
    end else if (u[15:10] == LOW_SURR_TAG) begin
      string_status = STATUS_SURROGATE;
    end else begin
      push_utf8_char({5'b00000, u});
    end
  endtask

  // Offer one unit after a random gap and wait for it to be taken. The valid
  // stays high across back-to-back beats.
  task automatic send_unit(input logic [UNIT_W-1:0] u, input exp_kind_t kind,
                           input utf8_beat_t typed);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= u;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_units++;
    encode_unit(u);
    case (kind)
      EXP_PRED: begin
        foreach (utf8_pending[i]) utf8_expected.push_back(utf8_pending[i]);
      end
      EXP_BEAT: begin
        utf8_expected.push_back(typed);
      end
      default: begin
      end
    endcase
  endtask

  // Hold the input off until every owed beat is out, then give a unit that
  // produced nothing time to clear the decode stage.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (utf8_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the capacity register, read it back, and update the shadow state.
  task automatic write_capacity(input logic [COUNT_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_OUTPUT_CAPACITY;
    pwdata <= {16'h0000, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    set_capacity(v);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== v) report("capacity readback", prdata[15:0], v);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly roomy capacities, with zero, tiny ones and ones near the length of
  // a random string so that the capacity error shows up regularly.
  function automatic logic [COUNT_W-1:0] pick_capacity();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(1, 12));
      4, 5: return 16'($urandom_range(20, 70));
      default: return 16'($urandom_range(100, 16'hFFFF));
    endcase
  endfunction

  // Result side: the ready drops for a random number of cycles before each
  // beat, with occasional bursts where it stays high.
  initial begin
    int stall;
    int eager_beats;
    eager_beats = 0;
    forever begin
      if (eager_beats > 0) begin
        eager_beats--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 7);
        if ($urandom_range(0, 15) == 0) eager_beats = $urandom_range(8, 40);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(rst_n && out_tvalid)) @(posedge clk);
    end
  end

  // Every accepted output beat is checked against the oldest expectation.
  utf8_beat_t want_beat;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (utf8_expected.size() == 0) begin
        report("beat with nothing expected", out_tdata, 32'h0);
      end else begin
        want_beat = utf8_expected.pop_front();
        if (out_tdata[7:0] !== want_beat.bval) begin
          report("out_byte", out_tdata[7:0], want_beat.bval);
        end
        if (out_tlast !== want_beat.last) report("last_of_run", out_tlast, want_beat.last);
        if (out_tuser !== want_beat.eos) report("end_of_string", out_tuser, want_beat.eos);
        if (out_tdata[23:8] !== want_beat.count) begin
          report("bytes_written", out_tdata[23:8], want_beat.count);
        end
        if (out_tdata[25:24] !== want_beat.status) begin
          report("status", out_tdata[25:24], want_beat.status);
        end
      end
      out_beats++;
    end
  end

  // Any accepted beat on either stream or the register port counts as
  // progress; a long quiet stretch means the block is stuck.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_utf16_to_utf8_encoder: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int len;
    int sel;
    logic [UNIT_W-1:0] u;
    capacity = CAPACITY_RESET;
    clear_string();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Register rows wait for the block to go quiet first.
    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].op == ROW_CAP) begin
        wait_idle();
        write_capacity(DIR_TAB[i].val);
      end else begin
        send_unit(DIR_TAB[i].val, DIR_TAB[i].kind, DIR_TAB[i].beat);
      end
    end

    // Random strings. Most units are well-formed characters and pairs; the
    // rest are lone or broken surrogates and raw noise. Capacity changes
    // land both between strings and in the middle of one.
    while (sent_units < DIR_N + RANDOM_UNITS) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        write_capacity(pick_capacity());
      end
      sender_eager = ($urandom_range(0, 4) == 0);
      len = $urandom_range(0, 16);
      for (int k = 0; k < len; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
          send_unit(16'($urandom_range(1, 16'h7F)), EXP_PRED, NO_BEAT);
        end else if (sel < 50) begin
          send_unit(16'($urandom_range(16'h80, 16'h7FF)), EXP_PRED, NO_BEAT);
        end else if (sel < 65) begin
          u = $urandom_range(0, 1) ? 16'($urandom_range(16'h800, 16'hD7FF))
                                   : 16'($urandom_range(16'hE000, 16'hFFFF));
          send_unit(u, EXP_PRED, NO_BEAT);
        end else if (sel < 85) begin
          send_unit(16'hD800 | 16'($urandom_range(0, 16'h3FF)), EXP_PRED, NO_BEAT);
          send_unit(16'hDC00 | 16'($urandom_range(0, 16'h3FF)), EXP_PRED, NO_BEAT);
        end else if (sel < 89) begin
          send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), EXP_PRED, NO_BEAT);
        end else if (sel < 93) begin
          send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), EXP_PRED, NO_BEAT);
          send_unit(16'($urandom_range(1, 16'hFFFF)), EXP_PRED, NO_BEAT);
        end else if (sel < 96) begin
          wait_idle();
          write_capacity(pick_capacity());
        end else begin
          send_unit(16'($urandom_range(0, 16'hFFFF)), EXP_PRED, NO_BEAT);
        end
      end
      send_unit(16'h0000, EXP_PRED, NO_BEAT);
    end

    // Drain: every owed beat must arrive, then nothing else may follow.
    in_tvalid <= 1'b0;
    while (utf8_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_utf16_to_utf8_encoder: PASS");
    end else begin
      $display("tb_utf16_to_utf8_encoder: FAIL");
    end
    $finish;
  end

endmodule
